[rtl/core/dts_pkg.sv]
`timescale 1ns / 1ps
// dts_pkg: shared types, codes and defaults for the dependency topological sort
// used by dts_edge_store and dependency_topological_sort_top
package dts_pkg;

    localparam int DEF_MAX_NODES = 32;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_RESOLVE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_NODE    = 2'd1,
        KIND_SUMMARY = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_UNKNOWN   = 2'd1,
        STS_CYCLE     = 2'd2,
        STS_OUT_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] node_index;
        logic [5:0] dep_index;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [4:0] sorted_node;
        status_t    status;
        logic [5:0] sorted_count;
        logic       last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_ACK,
        ST_DEG_RD,
        ST_DEG_ACC,
        ST_SEED,
        ST_PUSH,
        ST_POP,
        ST_POP_WAIT,
        ST_EMIT,
        ST_SUMMARY
    } state_t;

endpackage

[rtl/core/dts_edge_store.sv]
`timescale 1ns / 1ps
// dts_edge_store: dependents matrix, one row per node, with per-row valid bits
// depends on dts_pkg
module dts_edge_store
    import dts_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clr,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [MAX_NODES-1:0] wr_row,
    input  logic [AW-1:0]        rd_addr,
    output logic [MAX_NODES-1:0] rd_row
);

    logic [MAX_NODES-1:0] mem [MAX_NODES];
    logic [MAX_NODES-1:0] mem_q_reg;
    logic [MAX_NODES-1:0] valid_reg;
    logic                 valid_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        mem_q_reg   <= mem[rd_addr];
        valid_q_reg <= valid_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clr) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // rows never written since reset or clear read as empty
    assign rd_row = valid_q_reg ? mem_q_reg : '0;

endmodule

[rtl/core/dependency_topological_sort_top.sv]
`timescale 1ns / 1ps
// dependency_topological_sort_top: Kahn topological sort over a stored dependency graph
// depends on dts_pkg and dts_edge_store
//
// Items arrive on s_ as transactions and each one is worked to completion before the
// next is taken. An add that stores its edge, a rejected add, a clear or an unused code
// each give one acknowledgment. A resolve accepts the item, sweeps the edge memory for
// the in-degrees (one row read per node), seeds the ready queue from a scan of the
// nodes and pushes each ready node into the queue; for each sorted node it then reads
// the queue, reads its row, gives the result and scans its released dependents, and
// once the queue is found empty it gives the summary. It gives one result per sorted
// node and a closing summary flagged last. node_count is taken on cfg_ at any time but
// should only change while the block is idle.
module dependency_topological_sort_top
    import dts_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
    localparam int CW = $clog2(MAX_NODES + 1)
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data
);

    state_t state_reg, state_next;

    logic [5:0]           node_count_reg;
    logic [CW-1:0]        n_act;
    in_item_t             req_reg;
    status_t              status_reg, add_status;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        head_reg, tail_reg;
    logic [CW-1:0]        sorted_reg;
    logic [AW-1:0]        cur_reg;
    logic [MAX_NODES-1:0] mask_reg;
    logic [CW-1:0]        deg_reg [MAX_NODES];
    logic [AW-1:0]        fifo [MAX_NODES];
    logic [AW-1:0]        fifo_q_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg, out_next;

    logic                 accept, slot_free, load_out;
    logic [AW-1:0]        rd_addr;
    logic [MAX_NODES-1:0] row;
    logic                 store_wr, store_clr;
    logic [MAX_NODES-1:0] lane_act, seed_mask, zero_mask;
    logic [AW-1:0]        low_idx;

    assign cfg_ready = 1'b1;
    assign n_act     = (node_count_reg > 6'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_reg);
    assign slot_free = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        if (7'(s_data.node_index) >= 7'(n_act)) begin
            add_status = STS_OUT_RANGE;
        end else if (7'(s_data.dep_index) >= 7'(n_act)) begin
            add_status = STS_UNKNOWN;
        end else begin
            add_status = STS_OK;
        end
    end

    dts_edge_store #(.MAX_NODES(MAX_NODES)) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (store_clr),
        .wr_en   (store_wr),
        .wr_addr (req_reg.dep_index[AW-1:0]),
        .wr_row  (row | (MAX_NODES'(1) << req_reg.node_index)),
        .rd_addr (rd_addr),
        .rd_row  (row)
    );

    // per-lane masks and lowest pending push
    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            lane_act[j]  = CW'(j) < n_act;
            seed_mask[j] = lane_act[j] && (deg_reg[j] == '0);
            zero_mask[j] = lane_act[j] && row[j] && (deg_reg[j] == CW'(1));
        end
        low_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                low_idx = AW'(i);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.op)
                        OP_ADD:     state_next = (add_status == STS_OK) ? ST_ADD_WR : ST_ACK;
                        OP_RESOLVE: state_next = (n_act == '0) ? ST_SEED : ST_DEG_RD;
                        default:    state_next = ST_ACK;
                    endcase
                end
            end
            ST_ADD_WR:   state_next = ST_ACK;
            ST_ACK:      state_next = slot_free ? ST_IDLE : ST_ACK;
            ST_DEG_RD:   state_next = ST_DEG_ACC;
            ST_DEG_ACC: begin
                state_next = ((CW+1)'(cnt_reg) + 1'b1 == (CW+1)'(n_act)) ? ST_SEED : ST_DEG_RD;
            end
            ST_SEED:     state_next = ST_PUSH;
            ST_PUSH:     state_next = (mask_reg == '0) ? ST_POP : ST_PUSH;
            ST_POP:      state_next = (head_reg == tail_reg) ? ST_SUMMARY : ST_POP_WAIT;
            ST_POP_WAIT: state_next = ST_EMIT;
            ST_EMIT:     state_next = slot_free ? ST_PUSH : ST_EMIT;
            ST_SUMMARY:  state_next = slot_free ? ST_IDLE : ST_SUMMARY;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready   = 1'b0;
        store_wr  = 1'b0;
        store_clr = 1'b0;
        load_out  = 1'b0;
        rd_addr   = cur_reg;
        out_next  = '{kind: KIND_ACK, sorted_node: '0, status: STS_OK,
                      sorted_count: '0, last: 1'b1};
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                rd_addr   = s_data.dep_index[AW-1:0];
                store_clr = s_valid && (s_data.op == OP_CLEAR);
            end
            ST_ADD_WR: store_wr = 1'b1;
            ST_ACK: begin
                load_out        = slot_free;
                out_next.status = status_reg;
            end
            ST_DEG_RD:   rd_addr = cnt_reg[AW-1:0];
            ST_POP_WAIT: rd_addr = fifo_q_reg;
            ST_EMIT: begin
                load_out             = slot_free;
                out_next.kind        = KIND_NODE;
                out_next.sorted_node = 5'(cur_reg);
                out_next.last        = 1'b0;
            end
            ST_SUMMARY: begin
                load_out              = slot_free;
                out_next.kind         = KIND_SUMMARY;
                out_next.status       = (sorted_reg < n_act) ? STS_CYCLE : STS_OK;
                out_next.sorted_count = 6'(sorted_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= '0;
            m_valid_reg    <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            sorted_reg     <= '0;
            cnt_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                node_count_reg <= cfg_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && s_data.op == OP_RESOLVE) begin
                        head_reg   <= '0;
                        tail_reg   <= '0;
                        sorted_reg <= '0;
                        cnt_reg    <= '0;
                    end
                end
                ST_DEG_ACC: cnt_reg <= cnt_reg + 1'b1;
                ST_PUSH: begin
                    if (mask_reg != '0) begin
                        tail_reg <= tail_reg + 1'b1;
                    end
                end
                ST_POP: begin
                    if (head_reg != tail_reg) begin
                        head_reg <= head_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        sorted_reg <= sorted_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and lane registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg    <= s_data;
            status_reg <= (s_data.op == OP_ADD) ? add_status : STS_OK;
        end
        if (load_out) begin
            m_data_reg <= out_next;
        end
        if (state_reg == ST_POP_WAIT) begin
            cur_reg <= fifo_q_reg;
        end
        if (state_reg == ST_PUSH && mask_reg != '0) begin
            fifo[tail_reg[AW-1:0]] <= low_idx;
        end
        fifo_q_reg <= fifo[head_reg[AW-1:0]];

        case (state_reg)
            ST_SEED: mask_reg <= seed_mask;
            ST_PUSH: mask_reg[low_idx] <= 1'b0;
            ST_EMIT: begin
                if (slot_free) begin
                    mask_reg <= zero_mask;
                end
            end
            default: ;
        endcase

        for (int j = 0; j < MAX_NODES; j++) begin
            if (state_reg == ST_IDLE && accept && s_data.op == OP_RESOLVE) begin
                deg_reg[j] <= '0;
            end else if (state_reg == ST_DEG_ACC && lane_act[j]) begin
                deg_reg[j] <= deg_reg[j] + CW'(row[j]);
            end else if (state_reg == ST_EMIT && slot_free && lane_act[j] && row[j]
                         && deg_reg[j] != '0) begin
                deg_reg[j] <= deg_reg[j] - 1'b1;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg >= head_reg)
        else $error("ready queue read past its write pointer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (CW+1)'(tail_reg) <= (CW+1)'(MAX_NODES))
        else $error("ready queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SUMMARY |-> sorted_reg == head_reg)
        else $error("sorted count differs from nodes taken from the queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.last == (m_data_reg.kind != KIND_NODE)))
        else $error("last flag does not match result kind");

endmodule

[test/dts_sort_checker.sv]
`timescale 1ns / 1ps
// dts_sort_checker: watches the s_, m_ and cfg_ channels of the topological sort,
// predicts each result from its own copy of the edge matrix, and compares in order
// depends on dts_pkg
module dts_sort_checker
    import dts_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [5:0] cfg_data,
    output int        fail_count,
    output int        pending,
    output int        results_seen
);

    localparam int PRINT_CAP = 40;

    logic [MAX_NODES-1:0] dep_rows [MAX_NODES];
    logic [5:0]           node_limit;
    out_item_t            expected_results [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < PRINT_CAP)
            $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic int active_nodes();
        return (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
    endfunction

    function automatic out_item_t make_result(kind_t kind, int node, status_t status,
                                              int count, logic last);
        out_item_t r;
        r.kind         = kind;
        r.sorted_node  = node[4:0];
        r.status       = status;
        r.sorted_count = count[5:0];
        r.last         = last;
        return r;
    endfunction

    // kahn walk: ready queue seeded in ascending order, dependents visited ascending
    function automatic void predict_order();
        int     indeg [MAX_NODES];
        int     ready_q [$];
        int     n;
        int     cur;
        int     sorted_cnt;
        n = active_nodes();
        sorted_cnt = 0;
        for (int j = 0; j < n; j++) begin
            indeg[j] = 0;
            for (int i = 0; i < n; i++)
                if (dep_rows[i][j])
                    indeg[j]++;
        end
        for (int j = 0; j < n; j++)
            if (indeg[j] == 0)
                ready_q.push_back(j);
        while (ready_q.size() > 0) begin
            cur = ready_q.pop_front();
            expected_results.push_back(make_result(KIND_NODE, cur, STS_OK, 0, 1'b0));
            sorted_cnt++;
            for (int j = 0; j < n; j++) begin
                if (dep_rows[cur][j] && indeg[j] > 0) begin
                    indeg[j]--;
                    if (indeg[j] == 0)
                        ready_q.push_back(j);
                end
            end
        end
        expected_results.push_back(make_result(KIND_SUMMARY, 0,
            (sorted_cnt < n) ? STS_CYCLE : STS_OK, sorted_cnt, 1'b1));
    endfunction

    function automatic void predict_item(in_item_t item);
        int      n;
        status_t st;
        n = active_nodes();
        st = STS_OK;
        case (item.op)
            OP_RESOLVE: begin
                predict_order();
                return;
            end
            OP_ADD: begin
                if (int'(item.node_index) >= n)
                    st = STS_OUT_RANGE;
                else if (int'(item.dep_index) >= n)
                    st = STS_UNKNOWN;
                else
                    dep_rows[item.dep_index][item.node_index] = 1'b1;
            end
            OP_CLEAR: begin
                for (int i = 0; i < MAX_NODES; i++)
                    dep_rows[i] = '0;
            end
            default: ;
        endcase
        expected_results.push_back(make_result(KIND_ACK, 0, st, 0, 1'b1));
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            node_limit = '0;
            for (int i = 0; i < MAX_NODES; i++)
                dep_rows[i] = '0;
            expected_results.delete();
            fail_count   = 0;
            results_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                node_limit = cfg_data;
            if (s_valid && s_ready)
                predict_item(s_data);
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected, kind", int'(m_data.kind), -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.kind !== want.kind)
                        report_mismatch("kind", int'(m_data.kind), int'(want.kind));
                    if (m_data.sorted_node !== want.sorted_node)
                        report_mismatch("sorted_node", int'(m_data.sorted_node),
                                        int'(want.sorted_node));
                    if (m_data.status !== want.status)
                        report_mismatch("status", int'(m_data.status), int'(want.status));
                    if (m_data.sorted_count !== want.sorted_count)
                        report_mismatch("sorted_count", int'(m_data.sorted_count),
                                        int'(want.sorted_count));
                    if (m_data.last !== want.last)
                        report_mismatch("last", int'(m_data.last), int'(want.last));
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

[test/tb_dependency_topological_sort_top.sv]
`timescale 1ns / 1ps
// tb_dependency_topological_sort_top: stimulus and verdict for the topological sort
// depends on dts_pkg, dependency_topological_sort_top and dts_sort_checker
module tb_dependency_topological_sort_top;
    import dts_pkg::*;

    localparam int MAX_NODES  = DEF_MAX_NODES;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 400;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data = '0;

    logic       s_acc = 1'b0;
    logic       cfg_acc = 1'b0;
    int         fail_count;
    int         pending;
    int         results_seen;
    int         items_sent = 0;
    int         cfg_writes = 0;
    int         burst_left = 4;
    int         idle_cycles = 0;

    always #5 aclk = ~aclk;

    dependency_topological_sort_top #(.MAX_NODES(MAX_NODES)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    dts_sort_checker #(.MAX_NODES(MAX_NODES)) chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .results_seen(results_seen)
    );

    always @(posedge aclk) begin
        s_acc   <= s_valid && s_ready;
        cfg_acc <= cfg_valid && cfg_ready;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: changing stall modes, plus one long hold-off while input keeps coming
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= 120) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (mode_left % 5 != 0);
                endcase
            end
        end
    end

    task automatic send_item(input op_t op, input int node, input int dep);
        in_item_t item;
        item.op         = op;
        item.node_index = node[4:0];
        item.dep_index  = dep[5:0];
        s_valid <= 1'b1;
        s_data  <= item;
        do @(negedge aclk); while (!s_acc);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_node_count(input int value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value[5:0];
        do @(negedge aclk); while (!cfg_acc);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic random_phase(input int count, input int items);
        int n;
        int r;
        int a;
        int b;
        n = (count > MAX_NODES) ? MAX_NODES : count;
        write_node_count(count);
        if ($urandom_range(0, 1))
            send_item(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 63));
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60 && n >= 2) begin
                b = $urandom_range(1, n - 1);
                a = $urandom_range(0, b - 1);
                if ($urandom_range(0, 9) == 0)
                    send_item(OP_ADD, a, b);
                else
                    send_item(OP_ADD, b, a);
            end else if (r < 70) begin
                send_item(OP_ADD, $urandom_range(0, 31), $urandom_range(0, 63));
            end else if (r < 86) begin
                send_item(OP_RESOLVE, $urandom_range(0, 31), $urandom_range(0, 63));
            end else if (r < 93) begin
                send_item(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 63));
            end else begin
                send_item(OP_UNUSED, $urandom_range(0, 31), $urandom_range(0, 63));
            end
        end
        send_item(OP_RESOLVE, 0, 0);
    endtask

    initial begin
        int setting;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // no nodes registered yet
        send_item(OP_ADD, 0, 0);
        send_item(OP_RESOLVE, 31, 63);
        send_item(OP_UNUSED, 31, 63);

        write_node_count(4);
        send_item(OP_ADD, 1, 0);
        send_item(OP_ADD, 2, 1);
        send_item(OP_ADD, 3, 0);
        send_item(OP_ADD, 3, 0);
        send_item(OP_ADD, 2, 5);
        send_item(OP_ADD, 31, 63);
        send_item(OP_ADD, 0, 63);
        send_item(OP_RESOLVE, 0, 0);
        send_item(OP_ADD, 3, 3);
        send_item(OP_RESOLVE, 0, 0);
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_RESOLVE, 0, 0);

        write_node_count(32);
        send_item(OP_ADD, 31, 30);
        send_item(OP_ADD, 0, 31);
        send_item(OP_ADD, 5, 32);
        send_item(OP_ADD, 4, 5);
        send_item(OP_ADD, 5, 4);
        send_item(OP_RESOLVE, 0, 0);

        // lowered count leaves the cycle and the high edges outside the walk
        write_node_count(3);
        send_item(OP_RESOLVE, 0, 0);
        write_node_count(63);
        send_item(OP_RESOLVE, 0, 0);
        send_item(OP_CLEAR, 0, 0);

        for (int p = 0; p < 12; p++) begin
            case (p)
                0: setting = 32;
                1: setting = 63;
                2: setting = 0;
                3: setting = 1;
                4: setting = 2;
                8: setting = $urandom_range(11, 32);
                default: setting = $urandom_range(3, 10);
            endcase
            random_phase(setting, 28);
        end

        wait_idle();
        repeat (20) @(negedge aclk);
        $display("covered %0d items and %0d results over %0d node count writes",
                 items_sent, results_seen, cfg_writes);
        $display("counts from 0 to 63, cycles, self edges, unknown and out-of-range adds");
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results still outstanding", fail_count, pending);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
